>>> hw/rtl/lru_residency_tracker_defines.svh
// ----------------------------------------------------------------------------
// LRU residency tracker assertion macros
// Shared concurrent assertion forms used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_RESIDENCY_TRACKER_DEFINES_SVH
`define LRU_RESIDENCY_TRACKER_DEFINES_SVH

// Check a same-cycle implication, masked while reset is held
`define LRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication, masked while reset is held
`define LRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lrt_pkg.sv
// ----------------------------------------------------------------------------
// LRU residency tracker package
// Field widths, parameter defaults, status codes and sequencer states.
// ----------------------------------------------------------------------------
package lrt_pkg;

    // Parameter defaults
    localparam int unsigned NUM_OBJECTS_DEF = 1024;
    localparam int unsigned CAPACITY_DEF    = 64;

    // Fixed payload widths
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned EVICT_W  = 10;
    localparam int unsigned COUNT_W  = 7;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_MISS  = 2'd1,
        ST_EVICT = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Request sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_LINK,
        S_EVRD,
        S_EVWR,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/lrt_req_if.sv
// ----------------------------------------------------------------------------
// LRU residency tracker request channel
// Valid/ready channel carrying one requested object index.
// ----------------------------------------------------------------------------
interface lrt_req_if;
    logic                        valid;
    logic                        ready;
    logic [lrt_pkg::INDEX_W-1:0] object_index;

    modport source (output valid, output object_index, input ready);
    modport sink   (input valid, input object_index, output ready);
endinterface

>>> hw/rtl/lrt_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU residency tracker response channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface lrt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lrt_pkg::STATUS_W-1:0] status;
    logic [lrt_pkg::EVICT_W-1:0]  evicted_index;
    logic [lrt_pkg::COUNT_W-1:0]  resident_count;

    modport source (output valid, output status, output evicted_index,
                    output resident_count, input ready);
    modport sink   (input valid, input status, input evicted_index,
                    input resident_count, output ready);
endinterface

>>> hw/rtl/lrt_ram.sv
// ----------------------------------------------------------------------------
// LRU residency tracker RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lrt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lru_residency_tracker.sv
// ----------------------------------------------------------------------------
// LRU residency tracker
// Keeps up to CAPACITY object indices resident in least-recently-used order
// and reports hits, misses and evictions for each request.
// ----------------------------------------------------------------------------
// One request is taken at a time. After reset the block sweeps the residency
// flags to zero, one entry a cycle, over all NUM_OBJECTS entries, and accepts
// no request until the sweep ends. An out-of-range request then goes straight
// to the result, a hit to the most recent entry takes the lookup step, any
// other hit or miss adds the relink step, and a miss that evicts adds eviction
// read and write steps; the steps are set by the dependent read, unlink and
// relink operations on the two link memories, each with one read and one write
// port (flag with older link, and newer link). A new request is taken while a
// result still waits in the output register; the sequencer stalls at the end
// of the next request only if that result has not been taken by then.
`include "lru_residency_tracker_defines.svh"

module lru_residency_tracker #(
    parameter int unsigned NUM_OBJECTS = lrt_pkg::NUM_OBJECTS_DEF,
    parameter int unsigned CAPACITY    = lrt_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrt_req_if.sink    i_req,
    lrt_rsp_if.source  o_rsp
);

    localparam int unsigned IDX_W = $clog2(NUM_OBJECTS);
    localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
    localparam int unsigned A_W   = IDX_W + 1;
    localparam logic [OCC_W-1:0] OCC_CAP = OCC_W'(CAPACITY);

    // Sequencer and list state
    lrt_pkg::t_state          r_state, n_state;
    logic [IDX_W-1:0]         r_clr;
    logic [IDX_W-1:0]         r_mru;
    logic [IDX_W-1:0]         r_lru;
    logic [OCC_W-1:0]         r_occ;

    // Request working registers
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_victim;
    lrt_pkg::t_status         r_status;

    // Output register
    logic                          r_out_valid;
    lrt_pkg::t_status              r_out_status;
    logic [lrt_pkg::EVICT_W-1:0]   r_out_evict;
    logic [lrt_pkg::COUNT_W-1:0]   r_out_count;

    // Memory ports
    logic             a_we, a_re, b_we, b_re;
    logic [IDX_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [A_W-1:0]   a_wdata, a_rdata;
    logic [IDX_W-1:0] b_wdata, b_rdata;

    // Decoded request and read data
    logic             req_acc;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic             rd_flag;
    logic [IDX_W-1:0] rd_older;
    logic [IDX_W-1:0] rd_newer;
    logic             out_load;
    logic [31:0]      victim_ext;
    logic [31:0]      count_ext;

    // Check terms
    logic             occ_full;
    logic             evict_out;
    logic             acc_in;
    logic             st_look;
    logic             st_link;

    assign req_acc  = i_req.valid && i_req.ready;
    assign in_range = {1'b0, i_req.object_index} < (lrt_pkg::INDEX_W + 1)'(NUM_OBJECTS);
    assign in_idx   = i_req.object_index[IDX_W-1:0];
    assign rd_flag  = a_rdata[IDX_W];
    assign rd_older = a_rdata[IDX_W-1:0];
    assign rd_newer = b_rdata;

    // Flag and older link memory
    lrt_ram #(
        .WIDTH (A_W),
        .DEPTH (NUM_OBJECTS)
    ) u_ram_older (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    // Newer link memory
    lrt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_OBJECTS)
    ) u_ram_newer (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrt_pkg::S_CLEAR: begin
                if (r_clr == IDX_W'(NUM_OBJECTS - 1)) begin
                    n_state = lrt_pkg::S_IDLE;
                end
            end
            lrt_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_state = in_range ? lrt_pkg::S_LOOK : lrt_pkg::S_DONE;
                end
            end
            lrt_pkg::S_LOOK: begin
                n_state = (rd_flag && (r_idx == r_mru)) ? lrt_pkg::S_DONE
                                                         : lrt_pkg::S_LINK;
            end
            lrt_pkg::S_LINK: begin
                n_state = ((r_status == lrt_pkg::ST_MISS) && (r_occ == OCC_W'(CAPACITY)))
                        ? lrt_pkg::S_EVRD : lrt_pkg::S_DONE;
            end
            lrt_pkg::S_EVRD: n_state = lrt_pkg::S_EVWR;
            lrt_pkg::S_EVWR: n_state = lrt_pkg::S_DONE;
            lrt_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = lrt_pkg::S_IDLE;
                end
            end
            default: n_state = lrt_pkg::S_CLEAR;
        endcase
    end

    // Memory control and handshake outputs
    always_comb begin
        i_req.ready = 1'b0;
        out_load    = 1'b0;
        a_we        = 1'b0;
        a_waddr     = '0;
        a_wdata     = '0;
        a_re        = 1'b0;
        a_raddr     = in_idx;
        b_we        = 1'b0;
        b_waddr     = '0;
        b_wdata     = '0;
        b_re        = 1'b0;
        b_raddr     = in_idx;
        unique case (r_state)
            lrt_pkg::S_CLEAR: begin
                // Sweep the residency flags to zero
                a_we    = 1'b1;
                a_waddr = r_clr;
            end
            lrt_pkg::S_IDLE: begin
                // Fetch flag and both links of the requested entry
                i_req.ready = 1'b1;
                a_re        = req_acc && in_range;
                b_re        = req_acc && in_range;
            end
            lrt_pkg::S_LOOK: begin
                // Unlink a hit from the middle of the list
                if (rd_flag && (r_idx != r_mru) && (r_idx != r_lru)) begin
                    a_we    = 1'b1;
                    a_waddr = rd_newer;
                    a_wdata = {1'b1, rd_older};
                    b_we    = 1'b1;
                    b_waddr = rd_older;
                    b_wdata = rd_newer;
                end
            end
            lrt_pkg::S_LINK: begin
                // Link the entry at the most recent end
                a_we    = 1'b1;
                a_waddr = r_idx;
                a_wdata = {1'b1, r_mru};
                if (r_occ != '0) begin
                    b_we    = 1'b1;
                    b_waddr = r_mru;
                    b_wdata = r_idx;
                end
            end
            lrt_pkg::S_EVRD: begin
                // Drop the least recent entry and fetch its newer neighbour
                a_we    = 1'b1;
                a_waddr = r_lru;
                a_wdata = '0;
                b_re    = 1'b1;
                b_raddr = r_lru;
            end
            lrt_pkg::S_EVWR: begin
            end
            lrt_pkg::S_DONE: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    // Control and list registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrt_pkg::S_CLEAR;
            r_clr       <= '0;
            r_mru       <= '0;
            r_lru       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lrt_pkg::S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                lrt_pkg::S_LOOK: begin
                    if (rd_flag && (r_idx != r_mru) && (r_idx == r_lru)) begin
                        r_lru <= rd_newer;
                    end
                end
                lrt_pkg::S_LINK: begin
                    r_mru <= r_idx;
                    if (r_occ == '0) begin
                        r_lru <= r_idx;
                    end
                    if ((r_status == lrt_pkg::ST_MISS) && (r_occ != OCC_W'(CAPACITY))) begin
                        r_occ <= r_occ + OCC_W'(1);
                    end
                end
                lrt_pkg::S_EVWR: begin
                    r_lru <= b_rdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Request payload and result registers
    assign victim_ext = 32'(r_victim);
    assign count_ext  = 32'(r_occ);

    always_ff @(posedge i_clk) begin
        if ((r_state == lrt_pkg::S_IDLE) && req_acc) begin
            r_idx    <= in_idx;
            r_status <= in_range ? lrt_pkg::ST_HIT : lrt_pkg::ST_RANGE;
        end
        if (r_state == lrt_pkg::S_LOOK) begin
            r_status <= rd_flag ? lrt_pkg::ST_HIT : lrt_pkg::ST_MISS;
        end
        if (r_state == lrt_pkg::S_EVRD) begin
            r_victim <= r_lru;
            r_status <= lrt_pkg::ST_EVICT;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_evict  <= (r_status == lrt_pkg::ST_EVICT)
                          ? victim_ext[lrt_pkg::EVICT_W-1:0] : '0;
            r_out_count  <= count_ext[lrt_pkg::COUNT_W-1:0];
        end
    end

    // Response channel
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.evicted_index  = r_out_evict;
    assign o_rsp.resident_count = r_out_count;

    // Terms for the checks
    assign occ_full  = (r_occ == OCC_CAP);
    assign evict_out = r_out_valid && (r_out_status == lrt_pkg::ST_EVICT);
    assign acc_in    = req_acc && in_range;
    assign st_look   = (r_state == lrt_pkg::S_LOOK);
    assign st_link   = (r_state == lrt_pkg::S_LINK);

    // Checks
    `LRT_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_CAP, "occupancy over capacity")
    `LRT_ASSERT_IMP(a_evict_full, i_clk, i_rst_n, evict_out, occ_full, "eviction below capacity")
    `LRT_ASSERT_NXT(a_accept_look, i_clk, i_rst_n, acc_in, st_look, "request did not start lookup")
    `LRT_ASSERT_NXT(a_link_mru, i_clk, i_rst_n, st_link, r_mru == $past(r_idx), "mru not updated")

endmodule
